[rtl/softmax_row_unit_defines.svh]
// Assertion macros shared by the softmax row unit RTL.
// No dependencies.
`ifndef SOFTMAX_ROW_UNIT_DEFINES_SVH
`define SOFTMAX_ROW_UNIT_DEFINES_SVH
// Assert that a condition implies something in the same cycle.
`define SMX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Assert that a condition implies something in the next cycle.
`define SMX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[rtl/smx_pkg.sv]
// Package for the softmax row unit: widths, constants and the channel payload structs.
// No dependencies.
package smx_pkg;
	localparam int MaxColsDefault = 32;
	localparam int ScoreW = 16;
	localparam int ExpW = 17;
	localparam int SumW = 23;
	localparam int ProbW = 16;
	localparam int IdxW = 6;
	localparam int QuoW = 17;
	localparam int DivW = ExpW + 16;

	typedef struct packed {
		logic [ProbW-1:0] probability;
		logic [IdxW-1:0]  element_index;
		logic             last_of_row;
		logic             overflow;
	} res_t;

	typedef struct packed {
		logic signed [ScoreW-1:0] score;
		logic                     last_in_row;
	} item_t;
endpackage

[rtl/smx_if.sv]
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface smx_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/smx_ram.sv]
// Generic single-port write, single-port registered read RAM.
// No dependencies.
module smx_ram #(
	parameter int Width = 16,
	parameter int Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/smx_exp.sv]
// Multi-cycle exp(-d) approximation: bit-serial multiplies, one bit per cycle.
// Depends on smx_pkg.
module smx_exp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [smx_pkg::ScoreW-1:0]   d,
	output logic                         done,
	output logic [smx_pkg::ExpW-1:0]     result
);
	typedef enum logic [2:0] {IDLE, MUL_Y, MUL_A, MUL_FF, MUL_B, FIN} state_t;
	localparam logic [8:0]  Log2e = 9'd369;
	localparam logic [15:0] CoefA = 16'd43024;
	localparam logic [13:0] CoefB = 14'd10257;

	state_t       state_q;
	logic [4:0]   cnt_q;
	logic [15:0]  d_q;
	logic [24:0]  y_q;
	logic [15:0]  mcand_q;
	logic [15:0]  mplier_q;
	logic [31:0]  acc_q;
	logic [15:0]  lin_q;
	logic [16:0]  p;
	logic [7:0]   k;
	logic [31:0]  addend;

	assign addend = mplier_q[0] ? {16'd0, mcand_q} << cnt_q : 32'd0;
	assign k = y_q[24:16] > 9'd255 ? 8'hFF : y_q[23:16];
	assign p = 17'd65536 - {1'b0, lin_q} + {1'b0, acc_q[31:16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				IDLE: if (start) begin
					d_q <= d;
					acc_q <= '0;
					cnt_q <= '0;
					mcand_q <= d;
					mplier_q <= {7'd0, Log2e};
					state_q <= MUL_Y;
				end
				MUL_Y: begin
					acc_q <= acc_q + addend;
					mplier_q <= mplier_q >> 1;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd8) begin
						y_q <= acc_q[24:0] + addend[24:0];
						state_q <= MUL_A;
						cnt_q <= '0;
						acc_q <= '0;
						mcand_q <= acc_q[15:0] + addend[15:0];
						mplier_q <= CoefA;
					end
				end
				MUL_A: begin
					acc_q <= acc_q + addend;
					mplier_q <= mplier_q >> 1;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						lin_q <= 16'((acc_q + addend) >> 16);
						state_q <= MUL_FF;
						cnt_q <= '0;
						acc_q <= '0;
						mplier_q <= y_q[15:0];
					end
				end
				MUL_FF: begin
					acc_q <= acc_q + addend;
					mplier_q <= mplier_q >> 1;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						mcand_q <= 16'((acc_q + addend) >> 16);
						state_q <= MUL_B;
						cnt_q <= '0;
						acc_q <= '0;
						mplier_q <= {2'd0, CoefB};
					end
				end
				MUL_B: begin
					acc_q <= acc_q + addend;
					mplier_q <= mplier_q >> 1;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd13) state_q <= FIN;
				end
				FIN: begin
					if (d_q == '0) result <= 17'd65536;
					else if (k >= 8'd17) result <= '0;
					else result <= p >> k[4:0];
					done <= 1'b1;
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule

[rtl/smx_div.sv]
// Restoring bit-serial divider: (num<<16 + den/2) / den, one quotient bit per cycle.
// Depends on smx_pkg.
module smx_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [smx_pkg::ExpW-1:0]   num,
	input  logic [smx_pkg::SumW-1:0]   den,
	output logic                       done,
	output logic [smx_pkg::ProbW-1:0]  quo
);
	localparam int NW = smx_pkg::DivW;
	logic [NW-1:0]              n_q;
	logic [smx_pkg::SumW:0]     rem_q;
	logic [smx_pkg::SumW-1:0]   den_q;
	logic [NW-1:0]              q_q;
	logic [5:0]                 cnt_q;
	logic                       busy_q;
	logic [smx_pkg::SumW:0]     trial;
	logic [smx_pkg::SumW:0]     diff;

	assign trial = {rem_q[smx_pkg::SumW-1:0], n_q[NW-1]};
	assign diff = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				n_q <= {num, 16'd0} + NW'(den >> 1);
				den_q <= den;
				rem_q <= '0;
				q_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				n_q <= n_q << 1;
				if (!diff[smx_pkg::SumW]) begin
					rem_q <= diff;
					q_q <= {q_q[NW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					q_q <= {q_q[NW-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(NW - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
	assign quo = (q_q > NW'(65535)) ? 16'hFFFF : q_q[15:0];
endmodule

[rtl/softmax_row_unit.sv]
// Channel      | Dir | Payload
// in_ch        | in  | score (s16 Q7.8), last_in_row
// out_ch       | out | probability, element_index, last_of_row, overflow
// Load accepts one score per cycle. After the last score, each element goes through
// the row read and the bit-serial exp unit; then each element goes through the exp
// read, the serial divider and an output transaction.
// Reset clears all control state; the row memories need no clearing.
// Input is stalled during the compute and emit phases; output stalls hold the unit.
// Depends on smx_pkg, smx_if, smx_ram, smx_exp, smx_div and the defines header.
`include "softmax_row_unit_defines.svh"
module softmax_row_unit #(
	parameter int MaxCols = smx_pkg::MaxColsDefault
) (
	input logic clk,
	input logic arst_n,
	smx_if.sink   in_ch,
	smx_if.source out_ch
);
	localparam int AW = (MaxCols > 1) ? $clog2(MaxCols) : 1;
	localparam int CW = $clog2(MaxCols + 1);
	typedef enum logic [2:0] {LOAD, EXP_RD, EXP_RUN, DIV_RD, DIV_RUN, EMIT} state_t;

	state_t                       state_q;
	logic signed [15:0]           max_q;
	logic [CW-1:0]                cnt_q;
	logic [AW-1:0]                idx_q;
	logic [smx_pkg::SumW-1:0]     sum_q;
	logic                         ovf_q;
	logic                         ram_wait_q;
	logic [15:0]                  row_rd;
	logic [16:0]                  exp_rd;
	logic                         ex_start, ex_done, dv_start, dv_done;
	logic [16:0]                  ex_res;
	logic [15:0]                  dv_quo;
	logic                         acc;
	logic                         store;
	logic                         last_idx;
	smx_pkg::item_t               it;

	assign it = in_ch.data;
	assign in_ch.ready = (state_q == LOAD);
	assign acc = in_ch.valid && in_ch.ready;
	assign store = acc && (cnt_q < CW'(MaxCols));
	assign last_idx = (CW'(idx_q) + CW'(1) == cnt_q);
	assign ex_start = (state_q == EXP_RD) && ram_wait_q;
	assign dv_start = (state_q == DIV_RD) && ram_wait_q;

	smx_ram #(.Width(16), .Depth(MaxCols)) u_row (
		.clk, .we(store), .waddr(cnt_q[AW-1:0]), .wdata(it.score),
		.raddr(idx_q), .rdata(row_rd));
	smx_ram #(.Width(17), .Depth(MaxCols)) u_exp (
		.clk, .we(ex_done), .waddr(idx_q), .wdata(ex_res),
		.raddr(idx_q), .rdata(exp_rd));
	smx_exp u_exp_unit (.clk, .arst_n, .start(ex_start),
		.d(16'(max_q - $signed(row_rd))), .done(ex_done), .result(ex_res));
	smx_div u_div (.clk, .arst_n, .start(dv_start), .num(exp_rd), .den(sum_q),
		.done(dv_done), .quo(dv_quo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			max_q <= 16'sh8000;
			cnt_q <= '0;
			idx_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
			ram_wait_q <= 1'b0;
			out_ch.valid <= 1'b0;
		end else begin
			unique case (state_q)
				LOAD: if (acc) begin
					if (store) begin
						cnt_q <= cnt_q + CW'(1);
						if (it.score > max_q) max_q <= it.score;
					end else ovf_q <= 1'b1;
					if (it.last_in_row) begin
						state_q <= EXP_RD;
						idx_q <= '0;
						sum_q <= '0;
						ram_wait_q <= 1'b0;
					end
				end
				EXP_RD: begin
					ram_wait_q <= ~ram_wait_q;
					if (ram_wait_q) state_q <= EXP_RUN;
				end
				EXP_RUN: if (ex_done) begin
					sum_q <= sum_q + smx_pkg::SumW'(ex_res);
					ram_wait_q <= 1'b0;
					if (last_idx) begin
						idx_q <= '0;
						state_q <= DIV_RD;
					end else begin
						idx_q <= idx_q + AW'(1);
						state_q <= EXP_RD;
					end
				end
				DIV_RD: begin
					ram_wait_q <= ~ram_wait_q;
					if (ram_wait_q) state_q <= DIV_RUN;
				end
				DIV_RUN: if (dv_done) begin
					out_ch.data.probability <= dv_quo;
					out_ch.data.element_index <= smx_pkg::IdxW'(idx_q);
					out_ch.data.last_of_row <= last_idx;
					out_ch.data.overflow <= ovf_q;
					out_ch.valid <= 1'b1;
					state_q <= EMIT;
				end
				EMIT: if (out_ch.ready) begin
					out_ch.valid <= 1'b0;
					ram_wait_q <= 1'b0;
					if (last_idx) begin
						state_q <= LOAD;
						max_q <= 16'sh8000;
						cnt_q <= '0;
						ovf_q <= 1'b0;
						sum_q <= '0;
						idx_q <= '0;
					end else begin
						idx_q <= idx_q + AW'(1);
						state_q <= DIV_RD;
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end

	`SMX_ASSERT_IMP(a_no_in_busy, clk, arst_n, state_q != LOAD, !in_ch.ready)
	`SMX_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(MaxCols))
	`SMX_ASSERT_IMP(a_valid_emit, clk, arst_n, out_ch.valid, state_q == EMIT)
	`SMX_ASSERT_NEXT(a_out_done, clk, arst_n, out_ch.valid && out_ch.ready, !out_ch.valid)
endmodule

[verif/softmax_row_unit_tb.sv]
// Self-checking testbench for softmax_row_unit: directed and random rows of Q7.8 scores with
// randomized handshake idling on both channels, checked against a built-in predictor.
// Depends on smx_pkg, smx_if and the softmax_row_unit RTL.
module softmax_row_unit_tb;
	localparam int ColsLimit = smx_pkg::MaxColsDefault;
	localparam int CycleLimit = 2000000;
	localparam int RandItems = 410;

	logic clk;
	logic arst_n;

	smx_if #(.payload_t(smx_pkg::item_t)) in_ch (clk);
	smx_if #(.payload_t(smx_pkg::res_t)) out_ch (clk);

	softmax_row_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// stimulus queues: item, and whether to hold until all results are back
	smx_pkg::item_t score_queue[$];
	bit             drain_queue[$];
	smx_pkg::res_t  prob_queue[$];

	// predictor state
	logic signed [15:0] row_scores[ColsLimit];
	logic signed [15:0] row_max;
	int                 row_len;
	bit                 row_truncated;

	int  errors;
	int  cycles;
	bit  in_fire;
	bit  out_fire;
	int  send_wait;
	int  recv_wait;
	bit  no_idle;

	function automatic logic [16:0] exp_q16(logic [15:0] d);
		logic [31:0] y;
		logic [31:0] k;
		logic [63:0] f;
		logic [63:0] p;
		if (d == 16'd0)
			return 17'd65536;
		y = {16'd0, d} * 32'd369;
		k = y >> 16;
		f = {48'd0, y[15:0]};
		if (k >= 17)
			return 17'd0;
		p = 64'd65536 - ((f * 64'd43024) >> 16) + ((((f * f) >> 16) * 64'd10257) >> 16);
		return p[16:0] >> k;
	endfunction

	task automatic predict_softmax(smx_pkg::item_t it);
		logic [16:0] exps[ColsLimit];
		logic [22:0] sum;
		logic [63:0] q;
		smx_pkg::res_t r;
		if (row_len < ColsLimit) begin
			row_scores[row_len] = it.score;
			if (it.score > row_max)
				row_max = it.score;
			row_len++;
		end else begin
			row_truncated = 1'b1;
		end
		if (!it.last_in_row)
			return;
		sum = '0;
		for (int i = 0; i < row_len; i++) begin
			exps[i] = exp_q16(16'(32'(row_max) - 32'(row_scores[i])));
			sum = sum + 23'(exps[i]);
		end
		for (int i = 0; i < row_len; i++) begin
			q = (({47'd0, exps[i]} << 16) + {42'd0, sum[22:1]}) / {41'd0, sum};
			r.probability = (q > 64'd65535) ? 16'hFFFF : q[15:0];
			r.element_index = i[5:0];
			r.last_of_row = (i + 1 == row_len);
			r.overflow = row_truncated;
			prob_queue.push_back(r);
		end
		row_max = 16'sh8000;
		row_len = 0;
		row_truncated = 1'b0;
	endtask

	// acceptance, prediction and checking at the rising edge
	always @(posedge clk) begin
		in_fire <= arst_n && in_ch.valid && in_ch.ready;
		out_fire <= arst_n && out_ch.valid && out_ch.ready;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (cycles > CycleLimit) begin
				$display("softmax_row_unit_tb: FAIL");
				$finish;
			end
			if (in_ch.valid && in_ch.ready)
				predict_softmax(in_ch.data);
			if (out_ch.valid && out_ch.ready) begin
				if (prob_queue.size() == 0) begin
					$error("unexpected result transaction: %p", out_ch.data);
					errors++;
				end else begin
					smx_pkg::res_t e;
					e = prob_queue.pop_front();
					if (out_ch.data.probability !== e.probability) begin
						$error("probability exp %0d got %0d", e.probability,
							out_ch.data.probability);
						errors++;
					end
					if (out_ch.data.element_index !== e.element_index) begin
						$error("element_index exp %0d got %0d", e.element_index,
							out_ch.data.element_index);
						errors++;
					end
					if (out_ch.data.last_of_row !== e.last_of_row) begin
						$error("last_of_row exp %0d got %0d", e.last_of_row,
							out_ch.data.last_of_row);
						errors++;
					end
					if (out_ch.data.overflow !== e.overflow) begin
						$error("overflow exp %0d got %0d", e.overflow, out_ch.data.overflow);
						errors++;
					end
				end
			end
		end
	end

	// input driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire)
				send_wait = no_idle ? 0 : $urandom_range(0, 3);
			if (!in_ch.valid || in_fire) begin
				if (send_wait > 0) begin
					send_wait--;
					in_ch.valid <= 1'b0;
				end else if (score_queue.size() > 0 &&
						(!drain_queue[0] || prob_queue.size() == 0)) begin
					in_ch.data <= score_queue.pop_front();
					void'(drain_queue.pop_front());
					in_ch.valid <= 1'b1;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// output backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fire)
				recv_wait = no_idle ? 0 : $urandom_range(0, 3);
			if (recv_wait > 0) begin
				recv_wait--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	task automatic push_score(logic signed [15:0] s, bit last, bit drain = 1'b0);
		smx_pkg::item_t it;
		it.score = s;
		it.last_in_row = last;
		score_queue.push_back(it);
		drain_queue.push_back(drain);
	endtask

	task automatic push_row(int len, bit clustered, bit drain);
		logic signed [15:0] base;
		logic signed [15:0] s;
		base = 16'($urandom);
		for (int i = 0; i < len; i++) begin
			if (clustered)
				s = base + 16'($urandom_range(0, 2047)) - 16'sd1024;
			else
				s = 16'($urandom);
			push_score(s, i == len - 1, drain && i == 0);
		end
	endtask

	initial begin
		int total;
		int len;
		int pick;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		errors = 0;
		cycles = 0;
		send_wait = 0;
		recv_wait = 0;
		no_idle = 1'b0;
		row_max = 16'sh8000;
		row_len = 0;
		row_truncated = 1'b0;
		arst_n = 1'b0;

		// single element, full scale spread, mixed signs, ties
		push_score(16'sh7FFF, 1'b1);
		push_score(-16'sh8000, 1'b1);
		push_score(-16'sh8000, 1'b0);
		push_score(16'sh7FFF, 1'b1);
		push_score(16'sd0, 1'b0);
		push_score(16'sd256, 1'b0);
		push_score(-16'sd256, 1'b0);
		push_score(16'sd512, 1'b1);
		push_score(16'sd5, 1'b0);
		push_score(16'sd5, 1'b0);
		push_score(16'sd5, 1'b1);
		push_score(16'sh5555, 1'b0);
		push_score(-16'sh2AAB, 1'b0);
		push_score(16'sh5555, 1'b1, 1'b1);
		push_score(16'sd1, 1'b0);
		push_score(16'sd0, 1'b1);

		total = 0;
		while (total < RandItems) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				len = $urandom_range(1, 8);
			else if (pick < 9)
				len = $urandom_range(9, ColsLimit);
			else
				len = $urandom_range(ColsLimit + 1, ColsLimit + 8);
			push_row(len, $urandom_range(0, 2) != 0, $urandom_range(0, 9) == 0);
			total += len;
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (score_queue.size() > 0 || in_ch.valid) begin
			@(posedge clk);
			if (cycles % 3000 == 0)
				no_idle = !no_idle;
		end
		no_idle = 1'b0;
		wait (prob_queue.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && prob_queue.size() == 0)
			$display("softmax_row_unit_tb: PASS");
		else
			$display("softmax_row_unit_tb: FAIL");
		$finish;
	end
endmodule
